[sv/ssq7_pkg.sv]
package ssq7_pkg;

   // default geometry of the state store
   localparam int CHANNELS_DEF = 32;
   localparam int STATES_DEF   = 8;

   // field widths
   localparam int CH_W = 5;
   localparam int SI_W = 3;
   localparam int Q_W  = 8;
   localparam int H_W  = 16;

   // q7 arithmetic constants
   localparam int FRAC_BITS  = 7;
   localparam int ROUND_HALF = 64;
   localparam int Q7_MAX     = 127;
   localparam int Q7_MIN     = -127;

   // commands from the controller to the datapath
   typedef struct packed {
      logic clear_en;
      logic load;
      logic mul;
      logic rd;
      logic upd;
      logic wr_acc;
      logic out_load;
   } cmd_type;

   // status from the datapath to the controller
   typedef struct packed {
      logic clear_done;
      logic item_ok;
      logic last;
   } status_type;

endpackage

[sv/ssq7_datapath.sv]
module ssq7_datapath #(
   parameter int CHANNELS = ssq7_pkg::CHANNELS_DEF,
   parameter int STATES   = ssq7_pkg::STATES_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  ssq7_pkg::cmd_type                 cmd,
   output ssq7_pkg::status_type              status,
   input  logic [ssq7_pkg::CH_W-1:0]         req_channel,
   input  logic [ssq7_pkg::SI_W-1:0]         req_state_index,
   input  logic                              req_first_step,
   input  logic signed [ssq7_pkg::Q_W-1:0]   req_x_sample,
   input  logic signed [ssq7_pkg::Q_W-1:0]   req_step_size,
   input  logic signed [ssq7_pkg::Q_W-1:0]   req_a_coef,
   input  logic signed [ssq7_pkg::Q_W-1:0]   req_b_coef,
   input  logic signed [ssq7_pkg::Q_W-1:0]   req_c_coef,
   input  logic signed [ssq7_pkg::Q_W-1:0]   req_skip_coef,
   output logic signed [ssq7_pkg::Q_W-1:0]   rsp_y_out,
   output logic [ssq7_pkg::CH_W-1:0]         rsp_out_channel
);

   localparam int DEPTH  = CHANNELS * STATES;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   // captured transaction
   logic [ssq7_pkg::CH_W-1:0]       ch_ff;
   logic [ssq7_pkg::SI_W-1:0]       si_ff;
   logic                            first_ff;
   logic signed [ssq7_pkg::Q_W-1:0] x_ff, dt_ff, a_ff, b_ff, c_ff, skip_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         ch_ff    <= req_channel;
         si_ff    <= req_state_index;
         first_ff <= req_first_step;
         x_ff     <= req_x_sample;
         dt_ff    <= req_step_size;
         a_ff     <= req_a_coef;
         b_ff     <= req_b_coef;
         c_ff     <= req_c_coef;
         skip_ff  <= req_skip_coef;
      end
   end

   // range checks and state address
   logic [31:0]       addr_full;
   logic [ADDR_W-1:0] addr;

   assign addr_full = 32'(ch_ff) * 32'(STATES) + 32'(si_ff);
   assign addr      = addr_full[ADDR_W-1:0];

   assign status.item_ok = (32'(ch_ff) < 32'(CHANNELS)) && (32'(si_ff) < 32'(STATES));
   assign status.last    = (32'(si_ff) == 32'(STATES - 1));

   // clearing pass counter
   logic [ADDR_W-1:0] clr_cnt_ff, clr_cnt_in;

   assign clr_cnt_in        = clr_cnt_ff + ADDR_W'(1);
   assign status.clear_done = (clr_cnt_ff == ADDR_W'(DEPTH - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff <= '0;
      end else if (cmd.clear_en) begin
         clr_cnt_ff <= clr_cnt_in;
      end
   end

   // stage 1: rounded products for the transition and input gains, and the skip product
   logic signed [15:0] p_a, p_b, p_skip;
   logic signed [16:0] rnd_a, rnd_b;
   logic signed [7:0]  dta, db_in, da_in;
   logic signed [9:0]  da_sum;
   logic signed [8:0]  skx_in;
   logic signed [7:0]  da_ff, db_ff;
   logic signed [8:0]  skx_ff;

   assign p_a    = dt_ff * a_ff;
   assign p_b    = dt_ff * b_ff;
   assign p_skip = skip_ff * x_ff;
   assign rnd_a  = {p_a[15], p_a} + 17'(ssq7_pkg::ROUND_HALF);
   assign rnd_b  = {p_b[15], p_b} + 17'(ssq7_pkg::ROUND_HALF);
   assign dta    = rnd_a[14:7];
   assign db_in  = rnd_b[14:7];
   assign da_sum = {{2{dta[7]}}, dta} + 10'(ssq7_pkg::Q7_MAX);
   assign skx_in = p_skip[15:7];

   // clamp of the transition gain
   always_comb begin
      if (da_sum > ssq7_pkg::Q7_MAX) begin
         da_in = 8'(ssq7_pkg::Q7_MAX);
      end else if (da_sum < ssq7_pkg::Q7_MIN) begin
         da_in = 8'(ssq7_pkg::Q7_MIN);
      end else begin
         da_in = da_sum[7:0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.mul) begin
         da_ff  <= da_in;
         db_ff  <= db_in;
         skx_ff <= skx_in;
      end
   end

   // hidden state store
   logic signed [ssq7_pkg::H_W-1:0] mem [DEPTH];
   logic signed [ssq7_pkg::H_W-1:0] rd_ff;
   logic signed [ssq7_pkg::H_W-1:0] hn_ff, hn_in;

   always_ff @(posedge clock) begin
      if (cmd.clear_en) begin
         mem[clr_cnt_ff] <= '0;
      end else if (cmd.wr_acc) begin
         mem[addr] <= hn_ff;
      end
      if (cmd.rd) begin
         rd_ff <= mem[addr];
      end
   end

   // stage 2: state update
   logic signed [15:0] h_old;
   logic signed [8:0]  h_shr;
   logic signed [16:0] prod_h;
   logic signed [15:0] prod_x;
   logic signed [17:0] h_sum;

   assign h_old  = first_ff ? 16'sd0 : rd_ff;
   assign h_shr  = h_old[15:7];
   assign prod_h = da_ff * h_shr;
   assign prod_x = db_ff * x_ff;
   assign h_sum  = {prod_h[16], prod_h} + {{2{prod_x[15]}}, prod_x};
   assign hn_in  = 16'($signed(h_sum[17:7]));

   always_ff @(posedge clock) begin
      if (cmd.upd) begin
         hn_ff <= hn_in;
      end
   end

   // stage 3: output projection into the accumulator
   logic signed [7:0]  proj;
   logic signed [15:0] cprod, acc_base, acc_in, acc_ff;

   assign proj     = hn_ff[14:7];
   assign cprod    = c_ff * proj;
   assign acc_base = (si_ff == '0) ? 16'sd0 : acc_ff;
   assign acc_in   = acc_base + cprod;

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
      end else if (cmd.wr_acc) begin
         acc_ff <= acc_in;
      end
   end

   // stage 4: skip path, clamp and output register
   logic signed [9:0] y_sum;
   logic signed [7:0] y_in;
   logic signed [7:0] y_ff;
   logic [ssq7_pkg::CH_W-1:0] och_ff;

   assign y_sum = {acc_ff[15], acc_ff[15:7]} + {skx_ff[8], skx_ff};

   always_comb begin
      if (y_sum > ssq7_pkg::Q7_MAX) begin
         y_in = 8'(ssq7_pkg::Q7_MAX);
      end else if (y_sum < ssq7_pkg::Q7_MIN) begin
         y_in = 8'(ssq7_pkg::Q7_MIN);
      end else begin
         y_in = y_sum[7:0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         y_ff   <= y_in;
         och_ff <= ch_ff;
      end
   end

   assign rsp_y_out       = y_ff;
   assign rsp_out_channel = och_ff;

endmodule

[sv/ssq7_ctrl.sv]
module ssq7_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  ssq7_pkg::status_type status,
   output ssq7_pkg::cmd_type    cmd
);

   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_MUL   = 3'd2;
   localparam logic [2:0] ST_UPD   = 3'd3;
   localparam logic [2:0] ST_ACC   = 3'd4;
   localparam logic [2:0] ST_OUT   = 3'd5;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear_en = 1'b1;
            if (status.clear_done) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            if (status.item_ok) begin
               cmd.mul  = 1'b1;
               cmd.rd   = 1'b1;
               state_in = ST_UPD;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_UPD: begin
            cmd.upd  = 1'b1;
            state_in = ST_ACC;
         end
         ST_ACC: begin
            cmd.wr_acc = 1'b1;
            state_in   = status.last ? ST_OUT : ST_IDLE;
         end
         ST_OUT: begin
            if (out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // result valid flag
   always_comb begin
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

[sv/selective_scan_q7_state_update.sv]
// Q7 selective-scan state update, one state term per transaction.
// Input channel req_*: one term (channel, state index) with its x, dt and
// A, B, C, skip weights. Terms of one channel arrive in state order; index 0
// restarts the output sum, index STATES-1 produces one result transaction.
// Result channel rsp_*: the clamped Q7 output y and its channel.
// Sequence: a term is accepted, then takes the gain products, the state update,
// and the state write-back and accumulate in turn; the last term of a channel
// then loads the output register, waiting while an earlier result is still
// held and not taken. A term whose channel or state index is out of range
// is dropped at the gain-product step. The rate is set by the state memory
// read-modify-write and the chained multiplies of the controller sequence.
// Reset: the block first zeroes the state memory, one word per cycle, with
// req_ready low; the accumulator resets to zero.
// Stall: a finished result waits in the output register; the next terms are
// still taken, and only a further result waits until rsp_ready frees it.
module selective_scan_q7_state_update #(
   parameter int CHANNELS = ssq7_pkg::CHANNELS_DEF,
   parameter int STATES   = ssq7_pkg::STATES_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [ssq7_pkg::CH_W-1:0]         req_channel,
   input  logic [ssq7_pkg::SI_W-1:0]         req_state_index,
   input  logic                              req_first_step,
   input  logic signed [ssq7_pkg::Q_W-1:0]   req_x_sample,
   input  logic signed [ssq7_pkg::Q_W-1:0]   req_step_size,
   input  logic signed [ssq7_pkg::Q_W-1:0]   req_a_coef,
   input  logic signed [ssq7_pkg::Q_W-1:0]   req_b_coef,
   input  logic signed [ssq7_pkg::Q_W-1:0]   req_c_coef,
   input  logic signed [ssq7_pkg::Q_W-1:0]   req_skip_coef,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic signed [ssq7_pkg::Q_W-1:0]   rsp_y_out,
   output logic [ssq7_pkg::CH_W-1:0]         rsp_out_channel
);

   ssq7_pkg::cmd_type    cmd;
   ssq7_pkg::status_type status;

   // sequencer
   ssq7_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // arithmetic, state memory and output register
   ssq7_datapath #(
      .CHANNELS (CHANNELS),
      .STATES   (STATES)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_channel     (req_channel),
      .req_state_index (req_state_index),
      .req_first_step  (req_first_step),
      .req_x_sample    (req_x_sample),
      .req_step_size   (req_step_size),
      .req_a_coef      (req_a_coef),
      .req_b_coef      (req_b_coef),
      .req_c_coef      (req_c_coef),
      .req_skip_coef   (req_skip_coef),
      .rsp_y_out       (rsp_y_out),
      .rsp_out_channel (rsp_out_channel)
   );

endmodule

[sim/selective_scan_q7_state_update_test.sv]
`timescale 1ns / 100ps

module selective_scan_q7_state_update_test;

   localparam int CHANNELS       = ssq7_pkg::CHANNELS_DEF;
   localparam int STATES         = ssq7_pkg::STATES_DEF;
   localparam int TARGET_TERMS   = 750;
   localparam int QUIET_TAIL     = 150;
   localparam int SETTLE_CYCLES  = 20;
   localparam int WATCHDOG_LIMIT = 2000;

   // one scan term as seen on the input channel
   typedef struct {
      logic [ssq7_pkg::CH_W-1:0]        channel;
      logic [ssq7_pkg::SI_W-1:0]        state_index;
      logic                             first_step;
      logic signed [ssq7_pkg::Q_W-1:0]  x_sample;
      logic signed [ssq7_pkg::Q_W-1:0]  step_size;
      logic signed [ssq7_pkg::Q_W-1:0]  a_coef;
      logic signed [ssq7_pkg::Q_W-1:0]  b_coef;
      logic signed [ssq7_pkg::Q_W-1:0]  c_coef;
      logic signed [ssq7_pkg::Q_W-1:0]  skip_coef;
   } scan_term_type;

   // one channel output as seen on the result channel
   typedef struct {
      logic signed [ssq7_pkg::Q_W-1:0]  y_out;
      logic [ssq7_pkg::CH_W-1:0]        out_channel;
   } scan_output_type;

   // tracks hidden state and the output sum, predicts channel outputs
   class q7_scan_tracker;
      logic signed [ssq7_pkg::H_W-1:0] state_words [CHANNELS*STATES];
      logic signed [ssq7_pkg::H_W-1:0] scan_sum;
      scan_output_type                 pending_outputs [$];
      int                              mismatches;
      int                              terms_seen;
      int                              outputs_checked;

      function new();
         foreach (state_words[i]) state_words[i] = '0;
         scan_sum        = '0;
         mismatches      = 0;
         terms_seen      = 0;
         outputs_checked = 0;
      endfunction

      function int wrap8(int v);
         logic signed [7:0] t;
         t = v[7:0];
         return int'(t);
      endfunction

      function int wrap16(int v);
         logic signed [15:0] t;
         t = v[15:0];
         return int'(t);
      endfunction

      function int sat_q7(int v);
         if (v > ssq7_pkg::Q7_MAX) return ssq7_pkg::Q7_MAX;
         if (v < ssq7_pkg::Q7_MIN) return ssq7_pkg::Q7_MIN;
         return v;
      endfunction

      // apply one accepted term and queue the output it produces
      function void note_term(scan_term_type t);
         int dt, a, b, c, x, skip;
         int dta, da, db, h, hn, acc, y, idx;
         scan_output_type res;
         terms_seen++;
         if (int'(t.channel) >= CHANNELS || int'(t.state_index) >= STATES) return;
         dt   = t.step_size;
         a    = t.a_coef;
         b    = t.b_coef;
         c    = t.c_coef;
         x    = t.x_sample;
         skip = t.skip_coef;
         idx  = int'(t.channel) * STATES + int'(t.state_index);

         // discretized transition and input gain, rounded and wrapped to 8 bits
         dta = wrap8((dt * a + ssq7_pkg::ROUND_HALF) >>> ssq7_pkg::FRAC_BITS);
         da  = sat_q7(ssq7_pkg::Q7_MAX + dta);
         db  = wrap8((dt * b + ssq7_pkg::ROUND_HALF) >>> ssq7_pkg::FRAC_BITS);

         // state update, first time step reads the old state as zero
         h  = t.first_step ? 0 : int'(state_words[idx]);
         hn = wrap16((da * (h >>> ssq7_pkg::FRAC_BITS) + db * x) >>> ssq7_pkg::FRAC_BITS);
         state_words[idx] = hn[15:0];

         // output sum restarts at state index zero
         acc = (t.state_index == 0) ? 0 : int'(scan_sum);
         acc = wrap16(acc + c * wrap8(hn >>> ssq7_pkg::FRAC_BITS));
         scan_sum = acc[15:0];

         if (int'(t.state_index) == STATES - 1) begin
            y = sat_q7((acc >>> ssq7_pkg::FRAC_BITS) + ((skip * x) >>> ssq7_pkg::FRAC_BITS));
            res.y_out       = y[7:0];
            res.out_channel = t.channel;
            pending_outputs.push_back(res);
         end
      endfunction

      task report(string msg);
         $display("mismatch: %s", msg);
         mismatches++;
      endtask

      task check_output(logic signed [ssq7_pkg::Q_W-1:0] y, logic [ssq7_pkg::CH_W-1:0] ch);
         scan_output_type exp;
         if (pending_outputs.size() == 0) begin
            report($sformatf("unexpected output y_out %0d channel %0d", y, ch));
            return;
         end
         exp = pending_outputs.pop_front();
         outputs_checked++;
         if (y !== exp.y_out)
            report($sformatf("y_out got %0d expected %0d (channel %0d)",
                             y, exp.y_out, exp.out_channel));
         if (ch !== exp.out_channel)
            report($sformatf("out_channel got %0d expected %0d", ch, exp.out_channel));
      endtask

      function int outstanding();
         return pending_outputs.size();
      endfunction
   endclass

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_valid = 1'b0;
   logic                            req_ready;
   logic [ssq7_pkg::CH_W-1:0]       req_channel = '0;
   logic [ssq7_pkg::SI_W-1:0]       req_state_index = '0;
   logic                            req_first_step = 1'b0;
   logic signed [ssq7_pkg::Q_W-1:0] req_x_sample = '0;
   logic signed [ssq7_pkg::Q_W-1:0] req_step_size = '0;
   logic signed [ssq7_pkg::Q_W-1:0] req_a_coef = '0;
   logic signed [ssq7_pkg::Q_W-1:0] req_b_coef = '0;
   logic signed [ssq7_pkg::Q_W-1:0] req_c_coef = '0;
   logic signed [ssq7_pkg::Q_W-1:0] req_skip_coef = '0;
   logic                            rsp_valid;
   logic                            rsp_ready = 1'b0;
   logic signed [ssq7_pkg::Q_W-1:0] rsp_y_out;
   logic [ssq7_pkg::CH_W-1:0]       rsp_out_channel;

   q7_scan_tracker tracker = new();
   bit sender_gaps_on     = 1'b0;
   bit receiver_stalls_on = 1'b0;
   int terms_sent         = 0;
   int stall_left         = 0;
   int quiet_cycles       = 0;

   selective_scan_q7_state_update u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_channel     (req_channel),
      .req_state_index (req_state_index),
      .req_first_step  (req_first_step),
      .req_x_sample    (req_x_sample),
      .req_step_size   (req_step_size),
      .req_a_coef      (req_a_coef),
      .req_b_coef      (req_b_coef),
      .req_c_coef      (req_c_coef),
      .req_skip_coef   (req_skip_coef),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_y_out       (rsp_y_out),
      .rsp_out_channel (rsp_out_channel)
   );

   // 8 ns clock
   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   // result side back-pressure in random bursts, when stalls are enabled
   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_ready <= 1'b0;
         stall_left--;
      end else if (receiver_stalls_on && $urandom_range(0, 5) == 0) begin
         rsp_ready <= 1'b0;
         stall_left = $urandom_range(0, 16);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // transaction monitor and watchdog
   always @(posedge clock) begin : monitor
      bit moved;
      scan_term_type t;
      moved = 1'b0;
      if (!reset) begin
         if (req_valid && req_ready) begin
            t.channel     = req_channel;
            t.state_index = req_state_index;
            t.first_step  = req_first_step;
            t.x_sample    = req_x_sample;
            t.step_size   = req_step_size;
            t.a_coef      = req_a_coef;
            t.b_coef      = req_b_coef;
            t.c_coef      = req_c_coef;
            t.skip_coef   = req_skip_coef;
            tracker.note_term(t);
            moved = 1'b1;
         end
         if (rsp_valid && rsp_ready) begin
            tracker.check_output(rsp_y_out, rsp_out_channel);
            moved = 1'b1;
         end
      end
      quiet_cycles = moved ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
         $display("selective_scan_q7_state_update_test: errors");
         $finish;
      end
   end

   function automatic scan_term_type make_term(int ch, int si, bit first, int x, int dt,
                                               int a, int b, int c, int skip);
      scan_term_type t;
      t.channel     = ch[ssq7_pkg::CH_W-1:0];
      t.state_index = si[ssq7_pkg::SI_W-1:0];
      t.first_step  = first;
      t.x_sample    = x[7:0];
      t.step_size   = dt[7:0];
      t.a_coef      = a[7:0];
      t.b_coef      = b[7:0];
      t.c_coef      = c[7:0];
      t.skip_coef   = skip[7:0];
      return t;
   endfunction

   // random q7 value with extra weight on the extremes and zero
   function automatic int rand_q7();
      logic signed [7:0] v;
      case ($urandom_range(0, 9))
         0:       v = -8'sd128;
         1:       v = 8'sd127;
         2:       v = 8'sd0;
         default: v = 8'($urandom_range(0, 255));
      endcase
      return int'(v);
   endfunction

   // drive one term, optionally after an idle burst, and wait for acceptance
   task automatic send_term(scan_term_type t);
      if (sender_gaps_on && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(negedge clock);
      end
      req_channel     <= t.channel;
      req_state_index <= t.state_index;
      req_first_step  <= t.first_step;
      req_x_sample    <= t.x_sample;
      req_step_size   <= t.step_size;
      req_a_coef      <= t.a_coef;
      req_b_coef      <= t.b_coef;
      req_c_coef      <= t.c_coef;
      req_skip_coef   <= t.skip_coef;
      req_valid       <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
      terms_sent++;
   endtask

   // hold off the sender until every predicted output has been seen
   task automatic wait_for_outputs();
      req_valid <= 1'b0;
      do @(negedge clock); while (tracker.outstanding() != 0);
   endtask

   initial begin
      int r, lo, hi, ch, x, dt, skip;
      bit first;

      repeat (11) @(negedge clock);
      reset <= 1'b0;

      // directed: all-max scan on channel 0 from a fresh time step
      for (int si = 0; si < STATES; si++)
         send_term(make_term(0, si, 1'b1, 127, 127, 127, 127, 127, 127));
      // all-min on the top channel: rounded product wraps, dA becomes -1
      for (int si = 0; si < STATES; si++)
         send_term(make_term(CHANNELS - 1, si, 1'b0, -128, -128, -128, -128, -128, -128));
      // stray last term: sum carries over from the previous scan
      send_term(make_term(9, STATES - 1, 1'b0, 0, 0, 0, 0, 0, 0));
      // negative drive on channel 0 continuing its state, pushes y to the low clamp
      for (int si = 0; si < STATES; si++)
         send_term(make_term(0, si, 1'b0, -128, 127, -128, 127, 127, 127));
      wait_for_outputs();

      // random scans with gaps and stalls, quiet at the tail
      sender_gaps_on     = 1'b1;
      receiver_stalls_on = 1'b1;
      while (terms_sent < TARGET_TERMS) begin
         if (terms_sent >= TARGET_TERMS - QUIET_TAIL) begin
            sender_gaps_on     = 1'b0;
            receiver_stalls_on = 1'b0;
         end
         r     = $urandom_range(0, 19);
         ch    = $urandom_range(0, 1) ? $urandom_range(0, 3) : $urandom_range(0, CHANNELS - 1);
         first = ($urandom_range(0, 7) == 0);
         x     = rand_q7();
         dt    = rand_q7();
         skip  = rand_q7();
         if (r == 0) begin
            wait_for_outputs();
         end else if (r <= 16) begin
            // well-formed scan over all state indexes
            for (int si = 0; si < STATES; si++)
               send_term(make_term(ch, si, first, x, dt, rand_q7(), rand_q7(), rand_q7(), skip));
         end else if (r <= 18) begin
            // broken scan: starts or stops part way
            lo = $urandom_range(0, STATES - 1);
            hi = $urandom_range(lo, STATES - 1);
            for (int si = lo; si <= hi; si++)
               send_term(make_term(ch, si, first, x, dt, rand_q7(), rand_q7(), rand_q7(), skip));
         end else begin
            send_term(make_term(ch, $urandom_range(0, STATES - 1), first, x, dt,
                                rand_q7(), rand_q7(), rand_q7(), skip));
         end
      end

      wait_for_outputs();
      repeat (SETTLE_CYCLES) @(negedge clock);

      $display("%0d terms accepted, %0d channel outputs checked, %0d mismatches",
               tracker.terms_seen, tracker.outputs_checked, tracker.mismatches);
      $display("covered field extremes, in-order and broken scans, idle gaps and output stalls");
      if (tracker.mismatches == 0) begin
         $display("selective_scan_q7_state_update_test: clean");
      end else begin
         $display("selective_scan_q7_state_update_test: errors");
      end
      $finish;
   end

endmodule

[files.f]
sv/ssq7_pkg.sv
sv/ssq7_datapath.sv
sv/ssq7_ctrl.sv
sv/selective_scan_q7_state_update.sv
sim/selective_scan_q7_state_update_test.sv
